// File: rtl/nama_pkg.sv
`timescale 1ns / 1ps
package nama_pkg;
    localparam int SAMPLE_W = 16;
    localparam int MEAN_W   = 24;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RSQ    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAC   = 3'd5;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [7:0]          row;
        logic [7:0]          col;
        logic signed [15:0]  sample;
        logic                sample_valid;
    } req_t;

    typedef struct packed {
        logic signed [23:0] mean;
        logic               defined;
    } rsp_t;

    // handshake between the window scan and the divider
    typedef struct packed {
        logic               start;
        logic signed [31:0] sum;
        logic [12:0]        count;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [23:0] quot;
    } div_rsp_t;
endpackage

// File: rtl/nama_if.sv
`timescale 1ns / 1ps
interface nama_req_if;
    logic          valid;
    logic          ready;
    nama_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface nama_rsp_if;
    logic          valid;
    logic          ready;
    nama_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/nama_ram.sv
`timescale 1ns / 1ps
module nama_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/nama_div.sv
`timescale 1ns / 1ps
module nama_div (
    input  logic                clk,
    input  logic                rst_n,
    input  nama_pkg::div_req_t  req,
    output nama_pkg::div_rsp_t  rsp
);
    import nama_pkg::*;

    // restoring division of |sum|*256 by count, one quotient bit a cycle
    localparam int NUM_W = 40;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [13:0]      rem_reg, rem_next;
    logic [12:0]      den_reg;
    logic [5:0]       cnt_reg, cnt_next;
    logic             neg_reg, busy_reg, busy_next, done_reg;
    logic [31:0]      abs_sum;
    logic [13:0]      shifted;
    logic [NUM_W-1:0] qmag;

    assign abs_sum = req.sum[31] ? 32'(-req.sum) : 32'(req.sum);
    assign shifted = {rem_reg[12:0], num_reg[NUM_W-1]};

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (busy_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = shifted - {1'b0, den_reg};
                num_next = {num_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                num_next = {num_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 6'd1);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(NUM_W);
            end
            else
            begin
                busy_reg <= busy_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= {abs_sum, 8'd0};
            rem_reg <= '0;
            den_reg <= req.count;
            neg_reg <= req.sum[31];
        end
        else
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign qmag      = num_reg;
    assign rsp.done  = done_reg;
    assign rsp.quot  = neg_reg ? 24'(-qmag[23:0]) : qmag[23:0];
endmodule

// File: rtl/nama_scan.sv
`timescale 1ns / 1ps
module nama_scan #(
    parameter int MAX_ROWS   = 256,
    parameter int MAX_COLS   = 256,
    parameter int MAX_RADIUS = 31
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [7:0]          row,
    input  logic [7:0]          col,
    input  logic [8:0]          rows_cfg,
    input  logic [8:0]          cols_cfg,
    input  logic [4:0]          radius_cfg,
    input  logic [9:0]          rsq_cfg,
    input  logic                disk_cfg,
    input  logic [16:0]         frac_cfg,
    output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0] raddr,
    input  logic [16:0]         rdata,
    output nama_pkg::div_req_t  div_req,
    input  nama_pkg::div_rsp_t  div_rsp,
    output logic                busy,
    output logic                rsp_valid,
    output nama_pkg::rsp_t      rsp_data,
    input  logic                rsp_ready
);
    import nama_pkg::*;

    localparam int AW   = $clog2(MAX_ROWS*MAX_COLS);
    localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RADW = $clog2(MAX_RADIUS + 1) + 1;
    localparam int OW   = RADW + 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DRAIN = 6'b000100,
        S_CHECK = 6'b001000,
        S_DIV   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic signed [OW-1:0] d_reg, e_reg, r_s;
    logic signed [10:0]   rr, cc;
    logic [10:0]          rows_s, cols_s;
    logic [RADW-1:0]      r_sat;
    logic signed [31:0]   sum_reg;
    logic [12:0]          count_reg, area_reg;
    logic                 pend_reg, pend_next;
    logic [16:0]          frac_s;
    logic                 in_win, last_pos;
    logic [2*OW-1:0]      dsq, esq;
    logic [29:0]          lhs, rhs;
    logic                 def_reg;
    logic signed [23:0]   mean_reg;
    logic [7:0]           row_reg, col_reg;

    assign rows_s = (rows_cfg > 9'(MAX_ROWS)) ? 11'(MAX_ROWS) : 11'(rows_cfg);
    assign cols_s = (cols_cfg > 9'(MAX_COLS)) ? 11'(MAX_COLS) : 11'(cols_cfg);
    assign r_sat  = (32'(radius_cfg) > 32'(MAX_RADIUS)) ? RADW'(MAX_RADIUS)
                                                        : RADW'(radius_cfg);
    assign r_s    = OW'(r_sat);
    assign frac_s = (frac_cfg > 17'd65536) ? 17'd65536 : frac_cfg;

    assign rr  = 11'(signed'({3'b0, row_reg})) + 11'(d_reg);
    assign cc  = 11'(signed'({3'b0, col_reg})) + 11'(e_reg);
    assign dsq = (2*OW)'(d_reg) * (2*OW)'(d_reg);
    assign esq = (2*OW)'(e_reg) * (2*OW)'(e_reg);
    assign in_win = (rr >= 0) && (rr < signed'(rows_s)) && (cc >= 0)
                 && (cc < signed'(cols_s))
                 && (!disk_cfg || (32'(dsq) + 32'(esq) <= 32'(rsq_cfg)));
    assign last_pos = (d_reg == r_s) && (e_reg == r_s);
    assign raddr = AW'(32'(rr[RW-1:0]) * MAX_COLS + 32'(cc[CW-1:0]));

    assign lhs = 30'({count_reg, 16'd0});
    assign rhs = 30'(frac_s) * 30'(area_reg);

    always_comb
    begin
        state_next = state_reg;
        pend_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_SCAN;
            S_SCAN:
            begin
                pend_next = in_win;
                if (last_pos) state_next = S_DRAIN;
            end
            S_DRAIN: state_next = S_CHECK;
            S_CHECK: state_next = ((count_reg != 0) && (lhs >= rhs)) ? S_DIV : S_OUT;
            S_DIV:   if (div_rsp.done) state_next = S_OUT;
            S_OUT:   if (rsp_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                // query position is held for the whole scan
                row_reg   <= row;
                col_reg   <= col;
                d_reg     <= -r_s;
                e_reg     <= -r_s;
                sum_reg   <= '0;
                count_reg <= '0;
                area_reg  <= '0;
                def_reg   <= 1'b0;
                mean_reg  <= '0;
            end
            S_SCAN:
            begin
                if (e_reg == r_s)
                begin
                    e_reg <= -r_s;
                    d_reg <= d_reg + OW'(1);
                end
                else
                begin
                    e_reg <= e_reg + OW'(1);
                end
                if (in_win) area_reg <= area_reg + 13'd1;
            end
            S_CHECK: def_reg <= (count_reg != 0) && (lhs >= rhs);
            S_DIV:   if (div_rsp.done) mean_reg <= div_rsp.quot;
            default: ;
        endcase
        // memory data arrives in the cycle after its address
        if (pend_reg && rdata[16])
        begin
            count_reg <= count_reg + 13'd1;
            sum_reg   <= sum_reg + 32'(signed'(rdata[15:0]));
        end
    end

    assign div_req.start = (state_reg == S_CHECK) && (state_next == S_DIV);
    assign div_req.sum   = sum_reg;
    assign div_req.count = count_reg;

    assign busy          = (state_reg != S_IDLE);
    assign rsp_valid     = (state_reg == S_OUT);
    assign rsp_data.mean = mean_reg;
    assign rsp_data.defined = def_reg;
endmodule

// File: rtl/nan_aware_moving_avg_2d.sv
`timescale 1ns / 1ps
// Two-dimensional windowed mean over a stored frame with missing samples.
// A write item stores one sample and its present flag. A query
// scans the (2*radius+1)^2 window positions one per cycle through the single
// read port of the frame memory, then, if the mean is defined, a bit-serial
// divider forms the mean. The block takes one item at a time.
// Configuration is to be written only when idle; the block does not enforce it.
module nan_aware_moving_avg_2d #(
    parameter int MAX_ROWS   = 256,
    parameter int MAX_COLS   = 256,
    parameter int MAX_RADIUS = 31
) (
    input  logic        clk,
    input  logic        rst_n,
    nama_req_if.sink    req,
    nama_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    import nama_pkg::*;

    localparam int AW = $clog2(MAX_ROWS*MAX_COLS);

    logic [8:0]  rows_reg, cols_reg;
    logic [4:0]  radius_reg;
    logic [9:0]  rsq_reg;
    logic        disk_reg;
    logic [16:0] frac_reg;
    logic        busy, we, start;
    logic [AW-1:0] raddr, waddr;
    logic [16:0] rdata;
    div_req_t    dreq;
    div_rsp_t    drsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= 9'd256;
            cols_reg   <= 9'd256;
            radius_reg <= 5'd1;
            rsq_reg    <= 10'd1;
            disk_reg   <= 1'b0;
            frac_reg   <= 17'd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROWS:   rows_reg   <= cfg_data[8:0];
                CFG_COLS:   cols_reg   <= cfg_data[8:0];
                CFG_RADIUS: radius_reg <= cfg_data[4:0];
                CFG_RSQ:    rsq_reg    <= cfg_data[9:0];
                CFG_DISK:   disk_reg   <= cfg_data[0];
                CFG_FRAC:   frac_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign req.ready = !busy;
    assign start = req.valid && !busy && (req.data.req_type == REQ_QUERY);
    assign we = req.valid && !busy && (req.data.req_type == REQ_WRITE)
             && (32'(req.data.row) < MAX_ROWS) && (32'(req.data.col) < MAX_COLS);
    assign waddr = AW'(32'(req.data.row) * MAX_COLS + 32'(req.data.col));

    nama_ram #(.WIDTH(17), .DEPTH(MAX_ROWS*MAX_COLS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata ({req.data.sample_valid, req.data.sample}),
        .raddr (raddr),
        .rdata (rdata)
    );

    nama_scan #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .MAX_RADIUS(MAX_RADIUS)) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .row        (req.data.row),
        .col        (req.data.col),
        .rows_cfg   (rows_reg),
        .cols_cfg   (cols_reg),
        .radius_cfg (radius_reg),
        .rsq_cfg    (rsq_reg),
        .disk_cfg   (disk_reg),
        .frac_cfg   (frac_reg),
        .raddr      (raddr),
        .rdata      (rdata),
        .div_req    (dreq),
        .div_rsp    (drsp),
        .busy       (busy),
        .rsp_valid  (rsp.valid),
        .rsp_data   (rsp.data),
        .rsp_ready  (rsp.ready)
    );

    nama_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );
endmodule
